### src/hpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
// Holds the payload structs of both channels, request and status codes, and
// the default sizes. Depends on nothing.
package hpq_pkg;

    // Fixed widths of the channel fields.
    localparam int IN_KEY_W  = 32;
    localparam int IN_TAG_W  = 16;
    localparam int FILL_W    = 11;
    localparam int STATUS_W  = 2;

    // Default sizes handed to the top level.
    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    // Request codes.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Order modes.
    localparam logic ORDER_MAX = 1'b0;
    localparam logic ORDER_MIN = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // One request beat.
    typedef struct packed {
        logic                req_type;
        logic [IN_KEY_W-1:0] key;
        logic [IN_TAG_W-1:0] tag;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [IN_KEY_W-1:0] out_key;
        logic [IN_TAG_W-1:0] out_tag;
        logic                out_valid;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_level;
    } t_out_item;

endpackage

### src/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: sequencer, shared key
// comparator and output register. Depends on hpq_pkg and hpq_store.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall    o_out_data (t_out_item)
//   cfg       input      i_cfg_wr_en                  i_cfg_wr_data (order_mode)
//
// A push walks up and a pop walks down the heap, one level per step, over
// at most log2(CAPACITY) levels; a push when full or a pop when empty goes
// straight to the final state. The pace is set by the single memory read
// port and the one key comparator, visited once per step.
// Reset clears the entry count and the order mode; the memory is not cleared.
// The next beat is taken while a result waits in the output register; a
// stalled output holds the sequencer in its final state until the slot frees.
module binary_heap_priority_queue #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = hpq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = hpq_pkg::TAG_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hpq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hpq_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);

    import hpq_pkg::*;

    localparam int AW      = $clog2(CAPACITY);
    localparam int SW      = $clog2(CAPACITY + 1);
    localparam int ENTRY_W = KEY_BITS + TAG_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PU_RD,
        S_PU_CMP,
        S_PO_ROOT,
        S_PO_LAST,
        S_PO_GETLAST,
        S_SD_LEFT,
        S_SD_RIGHT,
        S_SD_PICK,
        S_SD_CMP,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_count, n_count;
    logic [SW-1:0]      r_slot, n_slot;
    logic [SW-1:0]      r_child, n_child;
    logic [ENTRY_W-1:0] r_req, n_req;
    logic [ENTRY_W-1:0] r_mk, n_mk;
    logic [ENTRY_W-1:0] r_ck, n_ck;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               r_order;

    // Memory port controls.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    // Shared comparator.
    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                beats;

    // Width conversions and address helpers.
    logic [KEY_BITS+IN_KEY_W-1:0] in_key_ext;
    logic [TAG_BITS+IN_TAG_W-1:0] in_tag_ext;
    logic [KEY_BITS+IN_KEY_W-1:0] out_key_ext;
    logic [TAG_BITS+IN_TAG_W-1:0] out_tag_ext;
    logic [FILL_W+SW-1:0]         fill_ext;
    logic [SW-1:0]                slot_m1, parent, parent_m1, count_m1;
    logic [SW:0]                  left, left_m1;
    logic                         accept;

    hpq_store #(
        .DEPTH(CAPACITY),
        .WIDTH(ENTRY_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (mem_we),
        .i_wr_addr(mem_waddr),
        .i_wr_data(mem_wdata),
        .i_rd_en  (mem_re),
        .i_rd_addr(mem_raddr),
        .o_rd_data(mem_rdata)
    );

    // Field conversions between channel widths and stored widths.
    assign in_key_ext  = {{KEY_BITS{1'b0}}, i_in_data.key};
    assign in_tag_ext  = {{TAG_BITS{1'b0}}, i_in_data.tag};
    assign out_key_ext = {{IN_KEY_W{1'b0}}, mem_rdata[ENTRY_W-1:TAG_BITS]};
    assign out_tag_ext = {{IN_TAG_W{1'b0}}, mem_rdata[TAG_BITS-1:0]};
    assign fill_ext    = {{FILL_W{1'b0}}, r_count};

    // Slot arithmetic; slots count from one, addresses from zero.
    assign slot_m1   = r_slot - SW'(1);
    assign parent    = r_slot >> 1;
    assign parent_m1 = parent - SW'(1);
    assign count_m1  = r_count - SW'(1);
    assign left      = {r_slot, 1'b0};
    assign left_m1   = left - (SW + 1)'(1);

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Comparator operand selection.
    always_comb begin
        cmp_a = r_ck[ENTRY_W-1:TAG_BITS];
        cmp_b = r_mk[ENTRY_W-1:TAG_BITS];
        unique case (r_state)
            S_PU_CMP: begin
                cmp_a = r_req[ENTRY_W-1:TAG_BITS];
                cmp_b = mem_rdata[ENTRY_W-1:TAG_BITS];
            end
            S_SD_PICK: begin
                cmp_a = mem_rdata[ENTRY_W-1:TAG_BITS];
                cmp_b = r_ck[ENTRY_W-1:TAG_BITS];
            end
            default: begin
            end
        endcase
    end

    assign beats = (r_order == ORDER_MIN) ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

    // Sequencer next state and memory controls.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_slot      = r_slot;
        n_child     = r_child;
        n_req       = r_req;
        n_mk        = r_mk;
        n_ck        = r_ck;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_waddr   = slot_m1[AW-1:0];
        mem_wdata   = r_mk;
        mem_re      = 1'b0;
        mem_raddr   = parent_m1[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = {in_key_ext[KEY_BITS-1:0], in_tag_ext[TAG_BITS-1:0]};
                    n_res = '0;
                    n_res.status = STATUS_OK;
                    if (i_in_data.req_type == REQ_PUSH) begin
                        if (r_count >= SW'(CAPACITY)) begin
                            n_res.status = STATUS_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_slot  = r_count + SW'(1);
                            n_state = S_PU_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = STATUS_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_PO_ROOT;
                        end
                    end
                end
            end
            S_PU_RD: begin
                if (r_slot == SW'(1)) begin
                    mem_we    = 1'b1;
                    mem_wdata = r_req;
                    n_count   = r_count + SW'(1);
                    n_state   = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_PU_CMP;
                end
            end
            S_PU_CMP: begin
                // Parent entry is on the read data.
                mem_we = 1'b1;
                if (beats) begin
                    mem_wdata = mem_rdata;
                    n_slot    = parent;
                    n_state   = S_PU_RD;
                end else begin
                    mem_wdata = r_req;
                    n_count   = r_count + SW'(1);
                    n_state   = S_DONE;
                end
            end
            S_PO_ROOT: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                n_state   = S_PO_LAST;
            end
            S_PO_LAST: begin
                // Root is on the read data; it is the result.
                n_res.out_key   = out_key_ext[IN_KEY_W-1:0];
                n_res.out_tag   = out_tag_ext[IN_TAG_W-1:0];
                n_res.out_valid = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = count_m1[AW-1:0];
                n_state   = S_PO_GETLAST;
            end
            S_PO_GETLAST: begin
                n_mk    = mem_rdata;
                n_count = count_m1;
                n_slot  = SW'(1);
                n_state = S_SD_LEFT;
            end
            S_SD_LEFT: begin
                if (left > {1'b0, r_count}) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = left_m1[AW-1:0];
                    n_child   = left[SW-1:0];
                    n_state   = S_SD_RIGHT;
                end
            end
            S_SD_RIGHT: begin
                n_ck = mem_rdata;
                if (r_child != r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_child[AW-1:0];
                    n_state   = S_SD_PICK;
                end else begin
                    n_state = S_SD_CMP;
                end
            end
            S_SD_PICK: begin
                // Right child wins only when it strictly beats the left.
                if (beats) begin
                    n_ck    = mem_rdata;
                    n_child = r_child + SW'(1);
                end
                n_state = S_SD_CMP;
            end
            S_SD_CMP: begin
                mem_we = 1'b1;
                if (beats) begin
                    mem_wdata = r_ck;
                    n_slot    = r_child;
                    n_state   = S_SD_LEFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out            = r_res;
                    n_out.fill_level = fill_ext[FILL_W-1:0];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_slot  <= n_slot;
        r_child <= n_child;
        r_req   <= n_req;
        r_mk    <= n_mk;
        r_ck    <= n_ck;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Order mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_MAX;
        end else if (i_cfg_wr_en) begin
            r_order <= i_cfg_wr_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(CAPACITY))
        else $error("entry count above capacity");

    // The count moves by at most one between cycles.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count)
                         || r_count == $past(r_count) + SW'(1)
                         || r_count == $past(r_count) - SW'(1)))
        else $error("entry count jumped");

    // A beat carrying a popped entry always reports success.
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_valid) |-> (o_out_data.status == STATUS_OK))
        else $error("popped entry with error status");

    // The memory is never written while the sequencer is idle.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory write while idle");

    // An accepted request keeps the input stalled in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input not stalled after accepted beat");

endmodule

### src/hpq_store.sv
// Entry memory of the heap: one write port and one read port with
// registered read data. Stands alone, uses no package.
module hpq_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data valid in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
